@@ src/pbc_pkg.sv @@
// Shared constants, types and command codes for the disc frame engine.
// No dependencies; every other file imports this package.
package pbc_pkg;

  localparam int DISC_COUNT = 64;
  localparam int SLOT_W     = 6;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_STEP = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ARENA_W = 3'd0,
    REG_ARENA_H = 3'd1,
    REG_GRAVITY = 3'd2,
    REG_DAMPING = 3'd3,
    REG_SETTLE  = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic signed [19:0] x;
    logic signed [19:0] y;
    logic        [13:0] r;
    logic signed [15:0] vx;
    logic signed [15:0] vy;
  } disc_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_CAP_A, OP_CAP_B, OP_CAP_OUT, OP_MOVE, OP_WALL,
    OP_DAMP_AVX, OP_DAMP_AVY, OP_DAMP_BVX, OP_DAMP_BVY,
    OP_DIFF, OP_D2A, OP_D2B, OP_RR,
    OP_SQ_INIT, OP_SQ_STEP,
    OP_DV_INIT_X, OP_DV_INIT_Y, OP_DV_STEP, OP_DV_END_X, OP_DV_END_Y,
    OP_OV, OP_SX, OP_SY, OP_SEP, OP_DVEL, OP_DN_A, OP_DN_B, OP_AX, OP_AY, OP_VUPD
  } dp_op_t;

  typedef enum logic [3:0] {
    M_DAMP_AVX, M_DAMP_AVY, M_DAMP_BVX, M_DAMP_BVY,
    M_DXDX, M_DYDY, M_RR, M_NXOV, M_NYOV, M_DVXNX, M_DVYNY, M_DNNX, M_DNNY
  } mul_sel_t;

  typedef enum logic [1:0] {
    WR_IN, WR_A, WR_B
  } wr_src_t;

  typedef struct packed {
    dp_op_t             op;
    mul_sel_t           msel;
    logic [SLOT_W-1:0]  rd_addr;
    logic               wr_en;
    wr_src_t            wr_src;
    logic [SLOT_W-1:0]  wr_addr;
  } dp_cmd_t;

  typedef struct packed {
    logic hit;
    logic skip;
    logic dn_neg;
    logic sq_done;
    logic dv_done;
  } dp_stat_t;

endpackage

@@ src/pbc_if.sv @@
// Request channels of the disc frame engine: input, result and register write.
// Depends on pbc_pkg.
interface pbc_in_if import pbc_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                command;
  logic [SLOT_W-1:0]   slot;
  logic signed [19:0]  pos_x;
  logic signed [19:0]  pos_y;
  logic        [13:0]  radius;
  logic signed [15:0]  vel_x;
  logic signed [15:0]  vel_y;
  modport source (output valid, command, slot, pos_x, pos_y, radius, vel_x, vel_y,
                  input ready);
  modport sink   (input valid, command, slot, pos_x, pos_y, radius, vel_x, vel_y,
                  output ready);
endinterface

interface pbc_out_if import pbc_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [SLOT_W-1:0]   out_slot;
  logic signed [19:0]  new_x;
  logic signed [19:0]  new_y;
  logic signed [15:0]  new_vx;
  logic signed [15:0]  new_vy;
  logic                last;
  modport source (output valid, out_slot, new_x, new_y, new_vx, new_vy, last,
                  input ready);
  modport sink   (input valid, out_slot, new_x, new_y, new_vx, new_vy, last,
                  output ready);
endinterface

interface pbc_cfg_if import pbc_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ src/pbc_datapath.sv @@
// Datapath: disc store with valid bits, working discs, shared multiplier,
// square root and divider units, register file. Depends on pbc_pkg.
module pbc_datapath import pbc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  dp_cmd_t               cmd,
  output dp_stat_t              stat,
  input  disc_t                 in_disc,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output disc_t                 out_disc
);

  function automatic logic signed [60:0] rshr(input logic signed [60:0] v, input int k);
    logic [60:0] mag;
    mag = v[60] ? 61'(-v) : 61'(v);
    mag = (mag + (61'(1) << (k - 1))) >> k;
    return v[60] ? -$signed(mag) : $signed(mag);
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [60:0] v);
    if (v > 61'sd32767) return 16'sh7FFF;
    if (v < -61'sd32768) return 16'sh8000;
    return v[15:0];
  endfunction

  function automatic logic signed [19:0] sat20(input logic signed [60:0] v);
    if (v > 61'sd524287) return 20'sh7FFFF;
    if (v < -61'sd524288) return 20'sh80000;
    return v[19:0];
  endfunction

  function automatic logic signed [15:0] neg16(input logic signed [15:0] v);
    return (v == 16'sh8000) ? 16'sh7FFF : -v;
  endfunction

  logic [10:0] arena_w_r, arena_h_r;
  logic [7:0]  grav_r, settle_r;
  logic [15:0] gain_r;

  disc_t                 mem [DISC_COUNT];
  logic [DISC_COUNT-1:0] vld_r;
  disc_t                 rd_data_r;
  logic                  rd_vld_r;
  disc_t                 rd_disc;
  disc_t                 wr_data;

  disc_t               a_r, b_r, out_r;
  logic                hit_r;
  logic signed [20:0]  dx_r, dy_r;
  logic [14:0]         rs_r;
  logic [41:0]         d2_r;
  logic [29:0]         rr_r;
  logic [45:0]         sq_n_r;
  logic [24:0]         sq_rem_r;
  logic [22:0]         dist_r;
  logic [4:0]          sq_cnt_r;
  logic [39:0]         dv_q_r;
  logic [23:0]         dv_rem_r;
  logic [5:0]          dv_cnt_r;
  logic                dv_neg_r;
  logic signed [17:0]  nx_r, ny_r;
  logic signed [23:0]  ov_r;
  logic signed [19:0]  sx_r, sy_r;
  logic signed [16:0]  dvx_r, dvy_r;
  logic signed [36:0]  dn_r;
  logic signed [19:0]  ix_r, iy_r;
  logic signed [60:0]  mul_r;

  logic signed [36:0]  mop_a;
  logic signed [23:0]  mop_b;

  // multiplier operand select
  always_comb begin
    mop_a = '0;
    mop_b = '0;
    case (cmd.msel)
      M_DAMP_AVX: begin mop_a = 37'(a_r.vx); mop_b = $signed({8'b0, gain_r}); end
      M_DAMP_AVY: begin mop_a = 37'(a_r.vy); mop_b = $signed({8'b0, gain_r}); end
      M_DAMP_BVX: begin mop_a = 37'(b_r.vx); mop_b = $signed({8'b0, gain_r}); end
      M_DAMP_BVY: begin mop_a = 37'(b_r.vy); mop_b = $signed({8'b0, gain_r}); end
      M_DXDX:     begin mop_a = 37'(dx_r); mop_b = 24'(dx_r); end
      M_DYDY:     begin mop_a = 37'(dy_r); mop_b = 24'(dy_r); end
      M_RR:       begin mop_a = $signed({22'b0, rs_r}); mop_b = $signed({9'b0, rs_r}); end
      M_NXOV:     begin mop_a = 37'(nx_r); mop_b = ov_r; end
      M_NYOV:     begin mop_a = 37'(ny_r); mop_b = ov_r; end
      M_DVXNX:    begin mop_a = 37'(dvx_r); mop_b = 24'(nx_r); end
      M_DVYNY:    begin mop_a = 37'(dvy_r); mop_b = 24'(ny_r); end
      M_DNNX:     begin mop_a = dn_r; mop_b = 24'(nx_r); end
      M_DNNY:     begin mop_a = dn_r; mop_b = 24'(ny_r); end
      default:    begin mop_a = '0; mop_b = '0; end
    endcase
  end

  // gravity and motion
  logic signed [15:0] mv_vy;
  logic signed [19:0] mv_x, mv_y;
  always_comb begin
    mv_vy = sat16(61'(a_r.vy) + $signed({53'b0, grav_r}));
    mv_x  = sat20(61'(a_r.x) + 61'(a_r.vx));
    mv_y  = sat20(61'(a_r.y) + 61'(mv_vy));
  end

  // walls: left, right, bottom, top
  logic signed [21:0] wx, wy, wr22, wlim, hlim;
  logic signed [15:0] wvx, wvy;
  logic [16:0]        wabs;
  logic               whit;
  always_comb begin
    wr22 = $signed({8'b0, a_r.r});
    wlim = $signed({3'b0, arena_w_r, 8'b0});
    hlim = $signed({3'b0, arena_h_r, 8'b0});
    wx   = 22'(a_r.x);
    wy   = 22'(a_r.y);
    wvx  = a_r.vx;
    wvy  = a_r.vy;
    whit = 1'b0;
    wabs = '0;
    if (wx - wr22 < 0) begin
      wx = wr22; wvx = neg16(wvx); whit = 1'b1;
    end
    if (wx + wr22 > wlim) begin
      wx = wlim - wr22; wvx = neg16(wvx); whit = 1'b1;
    end
    if (wy + wr22 > hlim) begin
      wy = hlim - wr22;
      wvy = neg16(wvy);
      wabs = wvy[15] ? (17'd0 - {wvy[15], wvy}) : {1'b0, wvy};
      if (wabs < {9'b0, settle_r}) wvy = '0;
      whit = 1'b1;
    end
    if (wy - wr22 < 0) begin
      wy = wr22; wvy = neg16(wvy); whit = 1'b1;
    end
  end

  // square root and divider steps
  logic [26:0] sq_rem2;
  logic [24:0] sq_trial;
  logic [24:0] dv_rem2;
  logic [20:0] adx, ady;
  always_comb begin
    sq_rem2  = {sq_rem_r, sq_n_r[45:44]};
    sq_trial = {dist_r, 2'b01};
    dv_rem2  = {dv_rem_r, dv_q_r[39]};
    adx      = dx_r[20] ? 21'(-dx_r) : 21'(dx_r);
    ady      = dy_r[20] ? 21'(-dy_r) : 21'(dy_r);
  end

  assign rd_disc = rd_vld_r ? rd_data_r : '0;

  always_comb begin
    case (cmd.wr_src)
      WR_IN:   wr_data = in_disc;
      WR_A:    wr_data = a_r;
      WR_B:    wr_data = b_r;
      default: wr_data = a_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_en) mem[cmd.wr_addr] <= wr_data;
    rd_data_r <= mem[cmd.rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r     <= '0;
      rd_vld_r  <= 1'b0;
      arena_w_r <= 11'd900;
      arena_h_r <= 11'd600;
      grav_r    <= 8'd26;
      gain_r    <= 16'd64225;
      settle_r  <= 8'd51;
    end else begin
      if (cmd.wr_en) vld_r[cmd.wr_addr] <= 1'b1;
      rd_vld_r <= vld_r[cmd.rd_addr];
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_idx))
          REG_ARENA_W: arena_w_r <= cfg_data[10:0];
          REG_ARENA_H: arena_h_r <= cfg_data[10:0];
          REG_GRAVITY: grav_r    <= cfg_data[7:0];
          REG_DAMPING: gain_r    <= cfg_data;
          REG_SETTLE:  settle_r  <= cfg_data[7:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    mul_r <= 61'(mop_a) * 61'(mop_b);
    case (cmd.op)
      OP_CAP_A:   a_r <= rd_disc;
      OP_CAP_B:   b_r <= rd_disc;
      OP_CAP_OUT: out_r <= rd_disc;
      OP_MOVE: begin
        a_r.vy <= mv_vy;
        a_r.x  <= mv_x;
        a_r.y  <= mv_y;
      end
      OP_WALL: begin
        a_r.x  <= 20'(wx);
        a_r.y  <= 20'(wy);
        a_r.vx <= wvx;
        a_r.vy <= wvy;
        hit_r  <= whit;
      end
      OP_DAMP_AVX: a_r.vx <= sat16(rshr(mul_r, 16));
      OP_DAMP_AVY: a_r.vy <= sat16(rshr(mul_r, 16));
      OP_DAMP_BVX: b_r.vx <= sat16(rshr(mul_r, 16));
      OP_DAMP_BVY: b_r.vy <= sat16(rshr(mul_r, 16));
      OP_DIFF: begin
        dx_r <= 21'(a_r.x) - 21'(b_r.x);
        dy_r <= 21'(a_r.y) - 21'(b_r.y);
        rs_r <= {1'b0, a_r.r} + {1'b0, b_r.r};
      end
      OP_D2A: d2_r <= mul_r[41:0];
      OP_D2B: d2_r <= d2_r + mul_r[41:0];
      OP_RR:  rr_r <= mul_r[29:0];
      OP_SQ_INIT: begin
        sq_n_r   <= {d2_r[29:0], 16'b0};
        sq_rem_r <= '0;
        dist_r   <= '0;
        sq_cnt_r <= 5'd23;
      end
      OP_SQ_STEP: begin
        if (sq_rem2 >= {2'b0, sq_trial}) begin
          sq_rem_r <= 25'(sq_rem2 - {2'b0, sq_trial});
          dist_r   <= {dist_r[21:0], 1'b1};
        end else begin
          sq_rem_r <= 25'(sq_rem2);
          dist_r   <= {dist_r[21:0], 1'b0};
        end
        sq_n_r   <= {sq_n_r[43:0], 2'b00};
        sq_cnt_r <= sq_cnt_r - 5'd1;
      end
      OP_DV_INIT_X: begin
        dv_q_r   <= {adx[15:0], 24'b0} + 40'(dist_r >> 1);
        dv_rem_r <= '0;
        dv_cnt_r <= 6'd40;
        dv_neg_r <= dx_r[20];
      end
      OP_DV_INIT_Y: begin
        dv_q_r   <= {ady[15:0], 24'b0} + 40'(dist_r >> 1);
        dv_rem_r <= '0;
        dv_cnt_r <= 6'd40;
        dv_neg_r <= dy_r[20];
      end
      OP_DV_STEP: begin
        if (dv_rem2 >= {2'b0, dist_r}) begin
          dv_rem_r <= 24'(dv_rem2 - {2'b0, dist_r});
          dv_q_r   <= {dv_q_r[38:0], 1'b1};
        end else begin
          dv_rem_r <= 24'(dv_rem2);
          dv_q_r   <= {dv_q_r[38:0], 1'b0};
        end
        dv_cnt_r <= dv_cnt_r - 6'd1;
      end
      OP_DV_END_X: nx_r <= dv_neg_r ? -$signed(dv_q_r[17:0]) : $signed(dv_q_r[17:0]);
      OP_DV_END_Y: ny_r <= dv_neg_r ? -$signed(dv_q_r[17:0]) : $signed(dv_q_r[17:0]);
      OP_OV: ov_r <= $signed({1'b0, rs_r, 8'b0}) - $signed({1'b0, dist_r});
      OP_SX: sx_r <= 20'(rshr(mul_r, 25));
      OP_SY: sy_r <= 20'(rshr(mul_r, 25));
      OP_SEP: begin
        a_r.x <= sat20(61'(a_r.x) + 61'(sx_r));
        a_r.y <= sat20(61'(a_r.y) + 61'(sy_r));
        b_r.x <= sat20(61'(b_r.x) - 61'(sx_r));
        b_r.y <= sat20(61'(b_r.y) - 61'(sy_r));
      end
      OP_DVEL: begin
        dvx_r <= 17'(b_r.vx) - 17'(a_r.vx);
        dvy_r <= 17'(b_r.vy) - 17'(a_r.vy);
      end
      OP_DN_A: dn_r <= 37'(mul_r);
      OP_DN_B: dn_r <= dn_r + 37'(mul_r);
      OP_AX:   ix_r <= 20'(rshr(mul_r, 32));
      OP_AY:   iy_r <= 20'(rshr(mul_r, 32));
      OP_VUPD: begin
        a_r.vx <= sat16(61'(a_r.vx) + 61'(ix_r));
        a_r.vy <= sat16(61'(a_r.vy) + 61'(iy_r));
        b_r.vx <= sat16(61'(b_r.vx) - 61'(ix_r));
        b_r.vy <= sat16(61'(b_r.vy) - 61'(iy_r));
      end
      default: ;
    endcase
  end

  always_comb begin
    stat.hit     = hit_r;
    stat.skip    = (d2_r == '0) || (d2_r >= {12'b0, rr_r});
    stat.dn_neg  = dn_r[36];
    stat.sq_done = (sq_cnt_r == '0);
    stat.dv_done = (dv_cnt_r == '0);
  end

  assign out_disc = out_r;

endmodule

@@ src/pbc_ctrl.sv @@
// Controller: sequences loads, the per-disc move, the pair sweep and the
// result emission by issuing datapath commands. Depends on pbc_pkg.
module pbc_ctrl import pbc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_command,
  input  logic [SLOT_W-1:0] in_slot,
  output logic              in_ready,
  input  logic              out_ready,
  output logic              out_valid,
  output logic [SLOT_W-1:0] out_slot,
  output logic              out_last,
  input  dp_stat_t          stat,
  output dp_cmd_t           cmd
);

  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(DISC_COUNT - 1);
  localparam logic [SLOT_W-1:0] PEN_SLOT  = SLOT_W'(DISC_COUNT - 2);

  typedef enum logic [5:0] {
    S_IDLE,
    S_MV_RD, S_MV_CAP, S_MV_MOVE, S_MV_WALL, S_MV_HIT, S_MV_DX, S_MV_DY, S_MV_WR,
    S_PR_RDI, S_PR_RDJ, S_PR_CAPJ, S_PR_DIFF, S_PR_M1, S_PR_M2, S_PR_M3, S_PR_M4,
    S_PR_CHK, S_PR_SQ, S_PR_DXI, S_PR_DXS, S_PR_DYI, S_PR_DYS, S_PR_OV,
    S_PR_S1, S_PR_S2, S_PR_S3, S_PR_SEP,
    S_PR_V0, S_PR_V1, S_PR_V2, S_PR_V3, S_PR_V4, S_PR_V5, S_PR_V6, S_PR_V7,
    S_PR_V8, S_PR_V9, S_PR_V10, S_PR_V11, S_PR_V12,
    S_PR_WRA, S_PR_WRB, S_PR_NEXT,
    S_EM_RD, S_EM_CAP, S_EM_WAIT
  } state_t;

  state_t            state_r, state_nxt;
  logic [SLOT_W-1:0] i_r, i_nxt, j_r, j_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [SLOT_W-1:0] out_slot_r, out_slot_nxt;
  logic              out_last_r, out_last_nxt;

  always_comb begin
    state_nxt     = state_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    out_valid_nxt = out_valid_r;
    out_slot_nxt  = out_slot_r;
    out_last_nxt  = out_last_r;
    in_ready      = 1'b0;
    cmd.op        = OP_NONE;
    cmd.msel      = M_DXDX;
    cmd.rd_addr   = i_r;
    cmd.wr_en     = 1'b0;
    cmd.wr_src    = WR_A;
    cmd.wr_addr   = i_r;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_command == CMD_STEP) begin
            i_nxt     = '0;
            state_nxt = S_MV_RD;
          end else if ({1'b0, in_slot} < (SLOT_W + 1)'(DISC_COUNT)) begin
            cmd.wr_en   = 1'b1;
            cmd.wr_src  = WR_IN;
            cmd.wr_addr = in_slot;
          end
        end
      end
      S_MV_RD:   state_nxt = S_MV_CAP;
      S_MV_CAP:  begin cmd.op = OP_CAP_A; state_nxt = S_MV_MOVE; end
      S_MV_MOVE: begin cmd.op = OP_MOVE;  state_nxt = S_MV_WALL; end
      S_MV_WALL: begin cmd.op = OP_WALL;  state_nxt = S_MV_HIT;  end
      S_MV_HIT: begin
        cmd.msel  = M_DAMP_AVX;
        state_nxt = stat.hit ? S_MV_DX : S_MV_WR;
      end
      S_MV_DX: begin
        cmd.op = OP_DAMP_AVX; cmd.msel = M_DAMP_AVY; state_nxt = S_MV_DY;
      end
      S_MV_DY: begin cmd.op = OP_DAMP_AVY; state_nxt = S_MV_WR; end
      S_MV_WR: begin
        cmd.wr_en = 1'b1;
        if (i_r == LAST_SLOT) begin
          i_nxt     = '0;
          j_nxt     = SLOT_W'(1);
          state_nxt = S_PR_RDI;
        end else begin
          i_nxt     = i_r + SLOT_W'(1);
          state_nxt = S_MV_RD;
        end
      end
      S_PR_RDI: state_nxt = S_PR_RDJ;
      S_PR_RDJ: begin cmd.rd_addr = j_r; cmd.op = OP_CAP_A; state_nxt = S_PR_CAPJ; end
      S_PR_CAPJ: begin cmd.op = OP_CAP_B; state_nxt = S_PR_DIFF; end
      S_PR_DIFF: begin cmd.op = OP_DIFF;  state_nxt = S_PR_M1; end
      S_PR_M1: begin cmd.msel = M_DXDX; state_nxt = S_PR_M2; end
      S_PR_M2: begin cmd.op = OP_D2A; cmd.msel = M_DYDY; state_nxt = S_PR_M3; end
      S_PR_M3: begin cmd.op = OP_D2B; cmd.msel = M_RR;   state_nxt = S_PR_M4; end
      S_PR_M4: begin cmd.op = OP_RR; state_nxt = S_PR_CHK; end
      S_PR_CHK: begin
        if (stat.skip) begin
          state_nxt = S_PR_NEXT;
        end else begin
          cmd.op    = OP_SQ_INIT;
          state_nxt = S_PR_SQ;
        end
      end
      S_PR_SQ: begin
        if (stat.sq_done) state_nxt = S_PR_DXI;
        else cmd.op = OP_SQ_STEP;
      end
      S_PR_DXI: begin cmd.op = OP_DV_INIT_X; state_nxt = S_PR_DXS; end
      S_PR_DXS: begin
        if (stat.dv_done) begin
          cmd.op = OP_DV_END_X; state_nxt = S_PR_DYI;
        end else begin
          cmd.op = OP_DV_STEP;
        end
      end
      S_PR_DYI: begin cmd.op = OP_DV_INIT_Y; state_nxt = S_PR_DYS; end
      S_PR_DYS: begin
        if (stat.dv_done) begin
          cmd.op = OP_DV_END_Y; state_nxt = S_PR_OV;
        end else begin
          cmd.op = OP_DV_STEP;
        end
      end
      S_PR_OV:  begin cmd.op = OP_OV; state_nxt = S_PR_S1; end
      S_PR_S1:  begin cmd.msel = M_NXOV; state_nxt = S_PR_S2; end
      S_PR_S2:  begin cmd.op = OP_SX; cmd.msel = M_NYOV; state_nxt = S_PR_S3; end
      S_PR_S3:  begin cmd.op = OP_SY; state_nxt = S_PR_SEP; end
      S_PR_SEP: begin cmd.op = OP_SEP; state_nxt = S_PR_V0; end
      S_PR_V0:  begin cmd.op = OP_DVEL; state_nxt = S_PR_V1; end
      S_PR_V1:  begin cmd.msel = M_DVXNX; state_nxt = S_PR_V2; end
      S_PR_V2:  begin cmd.op = OP_DN_A; cmd.msel = M_DVYNY; state_nxt = S_PR_V3; end
      S_PR_V3:  begin cmd.op = OP_DN_B; state_nxt = S_PR_V4; end
      S_PR_V4: begin
        cmd.msel  = M_DNNX;
        state_nxt = stat.dn_neg ? S_PR_WRA : S_PR_V5;
      end
      S_PR_V5:  begin cmd.op = OP_AX; cmd.msel = M_DNNY; state_nxt = S_PR_V6; end
      S_PR_V6:  begin cmd.op = OP_AY; state_nxt = S_PR_V7; end
      S_PR_V7:  begin cmd.op = OP_VUPD; state_nxt = S_PR_V8; end
      S_PR_V8:  begin cmd.msel = M_DAMP_AVX; state_nxt = S_PR_V9; end
      S_PR_V9: begin
        cmd.op = OP_DAMP_AVX; cmd.msel = M_DAMP_AVY; state_nxt = S_PR_V10;
      end
      S_PR_V10: begin
        cmd.op = OP_DAMP_AVY; cmd.msel = M_DAMP_BVX; state_nxt = S_PR_V11;
      end
      S_PR_V11: begin
        cmd.op = OP_DAMP_BVX; cmd.msel = M_DAMP_BVY; state_nxt = S_PR_V12;
      end
      S_PR_V12: begin cmd.op = OP_DAMP_BVY; state_nxt = S_PR_WRA; end
      S_PR_WRA: begin cmd.wr_en = 1'b1; state_nxt = S_PR_WRB; end
      S_PR_WRB: begin
        cmd.wr_en = 1'b1; cmd.wr_src = WR_B; cmd.wr_addr = j_r; state_nxt = S_PR_NEXT;
      end
      S_PR_NEXT: begin
        state_nxt = S_PR_RDI;
        if (j_r == LAST_SLOT) begin
          if (i_r == PEN_SLOT) begin
            i_nxt     = '0;
            state_nxt = S_EM_RD;
          end else begin
            i_nxt = i_r + SLOT_W'(1);
            j_nxt = i_r + SLOT_W'(2);
          end
        end else begin
          j_nxt = j_r + SLOT_W'(1);
        end
      end
      S_EM_RD: state_nxt = S_EM_CAP;
      S_EM_CAP: begin
        cmd.op        = OP_CAP_OUT;
        out_valid_nxt = 1'b1;
        out_slot_nxt  = i_r;
        out_last_nxt  = (i_r == LAST_SLOT);
        state_nxt     = S_EM_WAIT;
      end
      S_EM_WAIT: begin
        if (out_ready) begin
          out_valid_nxt = 1'b0;
          if (out_last_r) begin
            state_nxt = S_IDLE;
          end else begin
            i_nxt     = i_r + SLOT_W'(1);
            state_nxt = S_EM_RD;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      i_r         <= '0;
      j_r         <= '0;
      out_valid_r <= 1'b0;
      out_slot_r  <= '0;
      out_last_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      i_r         <= i_nxt;
      j_r         <= j_nxt;
      out_valid_r <= out_valid_nxt;
      out_slot_r  <= out_slot_nxt;
      out_last_r  <= out_last_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_slot  = out_slot_r;
  assign out_last  = out_last_r;

endmodule

@@ src/particle_bounce_collide_step_top.sv @@
// Top level of the disc frame engine: controller plus datapath on three
// request channels. Depends on pbc_pkg, pbc_if, pbc_ctrl and pbc_datapath.
//
// A load request writes one disc; the store reads as all zero after reset. A
// step request runs one frame and then returns 64 result requests, one per
// disc in slot order, the final one flagged by last. The frame time is set by
// the single read port and single write port of the disc store and the
// shared multiplier, square root and divider: a disc's move takes longer on
// a wall hit, which adds velocity damping; each of the 2016 pairs that does
// not touch stops after the distance check; an overlapping pair runs the
// 23-step square root and two 40-step divisions, and one that is approaching
// also updates and damps both velocities. Emission waits out any stall on
// the result side. New requests are taken only between frames; register
// writes are taken at any time and should be made while the engine is idle.
module particle_bounce_collide_step_top import pbc_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  pbc_in_if.sink    in_chan,
  pbc_out_if.source out_chan,
  pbc_cfg_if.sink   cfg_chan
);

  dp_cmd_t  cmd;
  dp_stat_t stat;
  disc_t    in_disc;
  disc_t    out_disc;

  assign in_disc.x  = in_chan.pos_x;
  assign in_disc.y  = in_chan.pos_y;
  assign in_disc.r  = in_chan.radius;
  assign in_disc.vx = in_chan.vel_x;
  assign in_disc.vy = in_chan.vel_y;

  assign cfg_chan.ready = 1'b1;

  pbc_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_chan.valid),
    .in_command (in_chan.command),
    .in_slot    (in_chan.slot),
    .in_ready   (in_chan.ready),
    .out_ready  (out_chan.ready),
    .out_valid  (out_chan.valid),
    .out_slot   (out_chan.out_slot),
    .out_last   (out_chan.last),
    .stat       (stat),
    .cmd        (cmd)
  );

  pbc_datapath u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .stat     (stat),
    .in_disc  (in_disc),
    .cfg_we   (cfg_chan.valid),
    .cfg_idx  (cfg_chan.index),
    .cfg_data (cfg_chan.data),
    .out_disc (out_disc)
  );

  assign out_chan.new_x  = out_disc.x;
  assign out_chan.new_y  = out_disc.y;
  assign out_chan.new_vx = out_disc.vx;
  assign out_chan.new_vy = out_disc.vy;

endmodule
